@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked, disabled while the low-active reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define NBR_ASSERT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NBR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/nbr_pkg.sv @@
// ----------------------------------------------------------------------------
// nbr_pkg
// types, operation codes and condition logic of the near branch resolver
// ----------------------------------------------------------------------------
package nbr_pkg;

    localparam int VIRT_ADDR_BITS_DEF = 48;

    localparam logic [63:0] RET_POP_BYTES = 64'd8;
    localparam logic [63:0] PUSH_BYTES    = 64'd8;

    localparam logic [4:0] OP_JCC_LAST  = 5'd15;
    localparam logic [4:0] OP_JMP_REL   = 5'd16;
    localparam logic [4:0] OP_JMP_IND   = 5'd17;
    localparam logic [4:0] OP_CALL_REL  = 5'd18;
    localparam logic [4:0] OP_CALL_IND  = 5'd19;
    localparam logic [4:0] OP_RET       = 5'd20;
    localparam logic [4:0] OP_RET_IMM   = 5'd21;
    localparam logic [4:0] OP_JCXZ      = 5'd22;
    localparam logic [4:0] OP_LOOP      = 5'd23;
    localparam logic [4:0] OP_LOOPE     = 5'd24;
    localparam logic [4:0] OP_LOOPNE    = 5'd25;

    // condition groups of the jcc code, bits 3:1
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_Z  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        logic [4:0]         opcode;
        logic [63:0]        cur_rip;
        logic [63:0]        cur_rsp;
        logic [63:0]        cur_rcx;
        logic [4:0]         flag_bits;
        logic signed [31:0] displacement;
        logic [63:0]        indirect_target;
        logic [63:0]        stack_word;
        logic [15:0]        stack_adjust;
        logic               wide_count;
    } nbr_in_t;

    typedef struct packed {
        logic [63:0] next_rip;
        logic [63:0] next_rsp;
        logic [63:0] next_rcx;
        logic        taken;
        logic        gp_fault;
        logic        push_valid;
        logic [63:0] push_address;
    } nbr_out_t;

    // resolved but not yet checked for canonical form
    typedef struct packed {
        logic        branch;
        logic        push;
        logic [63:0] target;
        logic [63:0] new_rsp;
        logic [63:0] new_rcx;
        logic [63:0] push_addr;
        logic [63:0] cur_rip;
        logic [63:0] cur_rsp;
        logic [63:0] cur_rcx;
    } nbr_exec_t;

    function automatic logic jcc_cond(input logic [3:0] code, input logic [4:0] flags);
        logic cf;
        logic pf;
        logic zf;
        logic sf;
        logic of;
        logic c;
        cf = flags[0];
        pf = flags[1];
        zf = flags[2];
        sf = flags[3];
        of = flags[4];
        case (code[3:1])
            CC_O:    c = of;
            CC_B:    c = cf;
            CC_Z:    c = zf;
            CC_BE:   c = cf | zf;
            CC_S:    c = sf;
            CC_P:    c = pf;
            CC_L:    c = sf ^ of;
            CC_LE:   c = zf | (sf ^ of);
            default: c = 1'b0;
        endcase
        return code[0] ? ~c : c;
    endfunction

endpackage

@@ hdl/nbr_exec.sv @@
// ----------------------------------------------------------------------------
// nbr_exec
// operation decode, address adders and branch condition for one beat
// ----------------------------------------------------------------------------
module nbr_exec (
    input  nbr_pkg::nbr_in_t   item,
    output nbr_pkg::nbr_exec_t res
);

    logic [63:0] disp64;
    logic [63:0] rel;
    logic [63:0] rcx_dec64;
    logic [63:0] rcx_dec;
    logic [63:0] ret_inc;
    logic [63:0] rsp_ret;
    logic [63:0] rsp_push;
    logic        rcx_zero;
    logic        zf;

    assign disp64    = {{32{item.displacement[31]}}, item.displacement};
    assign rel       = item.cur_rip + disp64;
    assign rcx_dec64 = item.cur_rcx - 64'd1;
    assign rcx_dec   = item.wide_count ? rcx_dec64 : {32'd0, rcx_dec64[31:0]};
    assign ret_inc   = (item.opcode == nbr_pkg::OP_RET_IMM)
                     ? ({48'd0, item.stack_adjust} + nbr_pkg::RET_POP_BYTES)
                     : nbr_pkg::RET_POP_BYTES;
    assign rsp_ret   = item.cur_rsp + ret_inc;
    assign rsp_push  = item.cur_rsp - nbr_pkg::PUSH_BYTES;
    assign rcx_zero  = item.wide_count ? (item.cur_rcx == 64'd0)
                                       : (item.cur_rcx[31:0] == 32'd0);
    assign zf        = item.flag_bits[2];

    always_comb begin
        res.branch    = 1'b0;
        res.push      = 1'b0;
        res.target    = item.cur_rip;
        res.new_rsp   = item.cur_rsp;
        res.new_rcx   = item.cur_rcx;
        res.push_addr = 64'd0;
        res.cur_rip   = item.cur_rip;
        res.cur_rsp   = item.cur_rsp;
        res.cur_rcx   = item.cur_rcx;
        if (item.opcode <= nbr_pkg::OP_JCC_LAST) begin
            res.branch = nbr_pkg::jcc_cond(item.opcode[3:0], item.flag_bits);
            res.target = rel;
        end else begin
            case (item.opcode)
                nbr_pkg::OP_JMP_REL: begin
                    res.branch = 1'b1;
                    res.target = rel;
                end
                nbr_pkg::OP_JMP_IND: begin
                    res.branch = 1'b1;
                    res.target = item.indirect_target;
                end
                nbr_pkg::OP_CALL_REL: begin
                    res.branch    = 1'b1;
                    res.push      = 1'b1;
                    res.target    = rel;
                    res.new_rsp   = rsp_push;
                    res.push_addr = rsp_push;
                end
                nbr_pkg::OP_CALL_IND: begin
                    res.branch    = 1'b1;
                    res.push      = 1'b1;
                    res.target    = item.indirect_target;
                    res.new_rsp   = rsp_push;
                    res.push_addr = rsp_push;
                end
                nbr_pkg::OP_RET, nbr_pkg::OP_RET_IMM: begin
                    res.branch  = 1'b1;
                    res.target  = item.stack_word;
                    res.new_rsp = rsp_ret;
                end
                nbr_pkg::OP_JCXZ: begin
                    res.branch = rcx_zero;
                    res.target = rel;
                end
                nbr_pkg::OP_LOOP: begin
                    res.target  = rel;
                    res.new_rcx = rcx_dec;
                    res.branch  = (rcx_dec != 64'd0);
                end
                nbr_pkg::OP_LOOPE: begin
                    res.target  = rel;
                    res.new_rcx = rcx_dec;
                    res.branch  = (rcx_dec != 64'd0) & zf;
                end
                nbr_pkg::OP_LOOPNE: begin
                    res.target  = rel;
                    res.new_rcx = rcx_dec;
                    res.branch  = (rcx_dec != 64'd0) & ~zf;
                end
                default: begin
                    // unused codes: registers pass through
                    res.branch = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ hdl/x86_64_near_branch_resolver.sv @@
// ----------------------------------------------------------------------------
// x86_64_near_branch_resolver
// three-stage near branch resolver for 64-bit mode
// ----------------------------------------------------------------------------
// One beat in, one beat out, at one beat per clock when the result side keeps
// up. Every beat passes three registers: an input register, then the decode
// and address adders (relative target, stack and count updates, condition),
// then the canonical check and fault selection into the output register. The
// result is offered on the m_ side straight from the output register. Each
// stage holds its own valid bit, so bubbles are squeezed out and s_ready drops
// only when all three stages are full and m_ready is low.
module x86_64_near_branch_resolver #(
    parameter int VIRT_ADDR_BITS = nbr_pkg::VIRT_ADDR_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nbr_pkg::nbr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nbr_pkg::nbr_out_t m_data
);

    `include "assert_macros.svh"

    localparam int HI_LSB = VIRT_ADDR_BITS - 1;

    logic               v0_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v0_next;
    logic               v1_next;
    logic               v2_next;
    logic               rdy0;
    logic               rdy1;
    logic               rdy2;
    nbr_pkg::nbr_in_t   s0_reg;
    nbr_pkg::nbr_exec_t s1_next;
    nbr_pkg::nbr_exec_t s1_reg;
    nbr_pkg::nbr_out_t  s2_next;
    nbr_pkg::nbr_out_t  s2_reg;
    logic               canonical;
    logic               fault;

    // a stage may load when it is empty or its beat moves on
    assign rdy2 = ~v2_reg | m_ready;
    assign rdy1 = ~v1_reg | rdy2;
    assign rdy0 = ~v0_reg | rdy1;

    assign v0_next = rdy0 ? s_valid : v0_reg;
    assign v1_next = rdy1 ? v0_reg  : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;

    assign s_ready = rdy0;
    assign m_valid = v2_reg;
    assign m_data  = s2_reg;

    nbr_exec u_exec (
        .item (s0_reg),
        .res  (s1_next)
    );

    // canonical: bits above the implemented range copy the top implemented bit
    assign canonical = (&s1_reg.target[63:HI_LSB]) | ~(|s1_reg.target[63:HI_LSB]);
    assign fault     = s1_reg.branch & ~canonical;

    always_comb begin
        if (fault) begin
            s2_next.next_rip     = s1_reg.cur_rip;
            s2_next.next_rsp     = s1_reg.cur_rsp;
            s2_next.next_rcx     = s1_reg.cur_rcx;
            s2_next.taken        = 1'b0;
            s2_next.gp_fault     = 1'b1;
            s2_next.push_valid   = 1'b0;
            s2_next.push_address = 64'd0;
        end else begin
            s2_next.next_rip     = s1_reg.branch ? s1_reg.target : s1_reg.cur_rip;
            s2_next.next_rsp     = s1_reg.new_rsp;
            s2_next.next_rcx     = s1_reg.new_rcx;
            s2_next.taken        = s1_reg.branch;
            s2_next.gp_fault     = 1'b0;
            s2_next.push_valid   = s1_reg.push;
            s2_next.push_address = s1_reg.push_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && rdy0) begin
            s0_reg <= s_data;
        end
        if (v0_reg && rdy1) begin
            s1_reg <= s1_next;
        end
        if (v1_reg && rdy2) begin
            s2_reg <= s2_next;
        end
    end

    `NBR_ASSERT_NEXT(a_accept_fills_s0, aclk, aresetn, s_valid && s_ready, v0_reg,
        "accepted beat missing from input stage")
    `NBR_ASSERT(a_fault_exclusive, aclk, aresetn, m_valid && m_data.gp_fault,
        !m_data.taken && !m_data.push_valid && m_data.push_address == 64'd0,
        "fault result also shows a transfer or push")
    `NBR_ASSERT(a_push_matches_rsp, aclk, aresetn, m_valid && m_data.push_valid,
        m_data.push_address == m_data.next_rsp && m_data.taken,
        "push address differs from new stack pointer")
    `NBR_ASSERT_NEXT(a_stalled_s1_holds, aclk, aresetn, v1_reg && !rdy2,
        v1_reg && $stable(s1_reg), "middle stage lost or changed a stalled beat")

endmodule

@@ tb/x86_64_near_branch_resolver_test.sv @@
// ----------------------------------------------------------------------------
// x86_64_near_branch_resolver_test
// self-checking bench for the 64-bit near branch resolver
// ----------------------------------------------------------------------------
// Beats are driven on the s_ channel. A scoreboard resolves every accepted beat
// on its own: condition codes, relative and indirect targets, stack and count
// updates, and the canonical-address fault. Each m_ beat is checked in order.
// A directed set covers every operation and the corner cases. Random beats
// follow, with bursty gaps on both sides and two long stalls of the result side.
module x86_64_near_branch_resolver_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VA_BITS = nbr_pkg::VIRT_ADDR_BITS_DEF;

    // opcodes with no operation behind them
    localparam logic [4:0] OP_NONE_LO = 5'd26;
    localparam logic [4:0] OP_NONE_HI = 5'd31;

    localparam int CF_BIT = 0;
    localparam int PF_BIT = 1;
    localparam int ZF_BIT = 2;
    localparam int SF_BIT = 3;
    localparam int OF_BIT = 4;

    localparam int RANDOM_BEATS   = 1525;
    localparam int QUIET_FROM     = 1350;
    localparam int SINK_STALL     = 64;

    class branch_scoreboard;
        nbr_pkg::nbr_out_t expected_q[$];
        int unsigned       errors;
        int unsigned       results_seen;

        function automatic bit is_canonical(logic [63:0] addr);
            logic [63:0] upper;
            logic [63:0] ones;
            ones  = '1;
            upper = addr >> (VA_BITS - 1);
            return (upper == 64'h0) || (upper == (ones >> (VA_BITS - 1)));
        endfunction

        function automatic bit cond_holds(logic [3:0] code, logic [4:0] fl);
            bit c;
            case (code[3:1])
                nbr_pkg::CC_O:  c = fl[OF_BIT];
                nbr_pkg::CC_B:  c = fl[CF_BIT];
                nbr_pkg::CC_Z:  c = fl[ZF_BIT];
                nbr_pkg::CC_BE: c = fl[CF_BIT] | fl[ZF_BIT];
                nbr_pkg::CC_S:  c = fl[SF_BIT];
                nbr_pkg::CC_P:  c = fl[PF_BIT];
                nbr_pkg::CC_L:  c = fl[SF_BIT] ^ fl[OF_BIT];
                default:        c = fl[ZF_BIT] | (fl[SF_BIT] ^ fl[OF_BIT]);
            endcase
            return code[0] ? !c : c;
        endfunction

        function automatic nbr_pkg::nbr_out_t resolve_branch(nbr_pkg::nbr_in_t b);
            logic [63:0]       rel;
            logic [63:0]       target;
            logic [63:0]       new_rsp;
            logic [63:0]       new_rcx;
            bit                branch;
            bit                push;
            nbr_pkg::nbr_out_t r;
            rel     = b.cur_rip + {{32{b.displacement[31]}}, b.displacement};
            target  = b.cur_rip;
            new_rsp = b.cur_rsp;
            new_rcx = b.cur_rcx;
            branch  = 1'b0;
            push    = 1'b0;
            if (b.opcode <= nbr_pkg::OP_JCC_LAST) begin
                branch = cond_holds(b.opcode[3:0], b.flag_bits);
                target = rel;
            end else begin
                case (b.opcode)
                    nbr_pkg::OP_JMP_REL: begin
                        branch = 1'b1;
                        target = rel;
                    end
                    nbr_pkg::OP_JMP_IND: begin
                        branch = 1'b1;
                        target = b.indirect_target;
                    end
                    nbr_pkg::OP_CALL_REL: begin
                        branch = 1'b1;
                        target = rel;
                        push   = 1'b1;
                    end
                    nbr_pkg::OP_CALL_IND: begin
                        branch = 1'b1;
                        target = b.indirect_target;
                        push   = 1'b1;
                    end
                    nbr_pkg::OP_RET: begin
                        branch  = 1'b1;
                        target  = b.stack_word;
                        new_rsp = b.cur_rsp + nbr_pkg::RET_POP_BYTES;
                    end
                    nbr_pkg::OP_RET_IMM: begin
                        branch  = 1'b1;
                        target  = b.stack_word;
                        new_rsp = b.cur_rsp + nbr_pkg::RET_POP_BYTES
                                + {48'h0, b.stack_adjust};
                    end
                    nbr_pkg::OP_JCXZ: begin
                        target = rel;
                        branch = b.wide_count ? (b.cur_rcx == 64'h0)
                                              : (b.cur_rcx[31:0] == 32'h0);
                    end
                    nbr_pkg::OP_LOOP, nbr_pkg::OP_LOOPE, nbr_pkg::OP_LOOPNE: begin
                        target  = rel;
                        new_rcx = b.wide_count ? b.cur_rcx - 64'h1
                                               : {32'h0, b.cur_rcx[31:0] - 32'h1};
                        branch  = new_rcx != 64'h0;
                        if (b.opcode == nbr_pkg::OP_LOOPE)
                            branch = branch && b.flag_bits[ZF_BIT];
                        if (b.opcode == nbr_pkg::OP_LOOPNE)
                            branch = branch && !b.flag_bits[ZF_BIT];
                    end
                    default: ;
                endcase
            end
            if (push)
                new_rsp = b.cur_rsp - nbr_pkg::PUSH_BYTES;

            r = '0;
            if (branch && !is_canonical(target)) begin
                // fault leaves all architectural state alone
                r.next_rip = b.cur_rip;
                r.next_rsp = b.cur_rsp;
                r.next_rcx = b.cur_rcx;
                r.gp_fault = 1'b1;
            end else begin
                r.next_rip     = branch ? target : b.cur_rip;
                r.next_rsp     = new_rsp;
                r.next_rcx     = new_rcx;
                r.taken        = branch;
                r.push_valid   = push;
                r.push_address = push ? b.cur_rsp - nbr_pkg::PUSH_BYTES : 64'h0;
            end
            return r;
        endfunction

        function void note_input(nbr_pkg::nbr_in_t b);
            expected_q.push_back(resolve_branch(b));
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] %s", $realtime, msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s: got %h, want %h",
                                 results_seen, name, got, want));
        endtask

        task check_result(nbr_pkg::nbr_out_t got);
            nbr_pkg::nbr_out_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing outstanding", results_seen));
            end else begin
                want = expected_q.pop_front();
                check_field("next_rip", got.next_rip, want.next_rip);
                check_field("next_rsp", got.next_rsp, want.next_rsp);
                check_field("next_rcx", got.next_rcx, want.next_rcx);
                check_field("taken", 64'(got.taken), 64'(want.taken));
                check_field("gp_fault", 64'(got.gp_fault), 64'(want.gp_fault));
                check_field("push_valid", 64'(got.push_valid), 64'(want.push_valid));
                check_field("push_address", got.push_address, want.push_address);
            end
            results_seen++;
        endtask
    endclass

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    nbr_pkg::nbr_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    nbr_pkg::nbr_out_t m_data;

    branch_scoreboard sb = new();

    int unsigned idle_pct   = 25;
    bit          stall_sink = 1'b0;

    x86_64_near_branch_resolver u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // random field values, biased towards the canonical boundaries

    function automatic logic [63:0] pick_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return {17'h00000, r[46:0]};
            1:       return {17'h1FFFF, r[46:0]};
            2:       return 64'h0000_7FFF_FFFF_FF00 + 64'($urandom_range(0, 511));
            3:       return 64'hFFFF_8000_0000_0100 - 64'($urandom_range(0, 511));
            default: return r;
        endcase
    endfunction

    function automatic logic [63:0] pick_count();
        case ($urandom_range(0, 3))
            0:       return {$urandom, 32'($urandom_range(0, 2))};
            1:       return 64'($urandom_range(0, 2));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] pick_opcode();
        if ($urandom_range(0, 19) == 0)
            return 5'($urandom_range(OP_NONE_LO, OP_NONE_HI));
        return 5'($urandom_range(0, nbr_pkg::OP_LOOPNE));
    endfunction

    function automatic nbr_pkg::nbr_in_t random_beat(logic [4:0] op);
        nbr_pkg::nbr_in_t b;
        b.opcode          = op;
        b.cur_rip         = pick_addr();
        b.cur_rsp         = {$urandom, $urandom};
        b.cur_rcx         = pick_count();
        b.flag_bits       = 5'($urandom);
        b.displacement    = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 255)) - 32'd128
                                                        : 32'($urandom);
        b.indirect_target = pick_addr();
        b.stack_word      = pick_addr();
        b.stack_adjust    = 16'($urandom);
        b.wide_count      = 1'($urandom);
        return b;
    endfunction

    // ------------------------------------------------------------------
    // s_ side

    task send_beat(nbr_pkg::nbr_in_t b);
        s_valid <= 1'b1;
        s_data  <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_input(b);
    endtask

    task maybe_pause_sender();
        if (!stall_sink && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task run_directed();
        nbr_pkg::nbr_in_t b;
        for (int k = 0; k <= nbr_pkg::OP_JCC_LAST; k++) begin
            b = random_beat(5'(k));
            if (k % 3 == 0)
                b.displacement = 32'h8000_0000;
            else if (k % 3 == 1)
                b.displacement = 32'h7FFF_FFFF;
            if (k == 4) begin
                // jz taken across the top of the lower canonical half
                b.flag_bits    = '0;
                b.flag_bits[ZF_BIT] = 1'b1;
                b.cur_rip      = 64'h0000_7FFF_FFFF_FFF0;
                b.displacement = 32'h100;
            end
            send_beat(b);
            maybe_pause_sender();
        end

        b = random_beat(nbr_pkg::OP_JMP_REL);
        b.cur_rip      = 64'h0;
        b.displacement = 32'hFFFF_FFFF;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_JMP_IND);
        b.indirect_target = 64'h0000_8000_0000_0000;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_CALL_REL);
        b.cur_rsp = 64'h0;
        send_beat(b);
        maybe_pause_sender();
        b = random_beat(nbr_pkg::OP_CALL_IND);
        b.indirect_target = 64'h8000_0000_0000_0000;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_RET);
        b.cur_rsp    = 64'hFFFF_FFFF_FFFF_FFFC;
        b.stack_word = 64'hFFFF_FFFF_FFFF_FFFF;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_RET_IMM);
        b.stack_adjust = 16'hFFFF;
        b.stack_word   = 64'h0000_7FFF_FFFF_FFFF;
        send_beat(b);
        maybe_pause_sender();
        // only the low half of the count is looked at in narrow mode
        b = random_beat(nbr_pkg::OP_JCXZ);
        b.cur_rcx    = 64'hFFFF_FFFF_0000_0000;
        b.wide_count = 1'b0;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_LOOP);
        b.cur_rcx    = 64'hABCD_0000_0000_0000;
        b.wide_count = 1'b0;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_LOOP);
        b.cur_rcx    = 64'h1;
        b.wide_count = 1'b1;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_LOOPE);
        b.cur_rcx = 64'h5;
        b.flag_bits[ZF_BIT] = 1'b1;
        send_beat(b);
        b = random_beat(nbr_pkg::OP_LOOPNE);
        b.cur_rcx = 64'h5;
        b.flag_bits[ZF_BIT] = 1'b1;
        send_beat(b);
        b = random_beat(OP_NONE_HI);
        send_beat(b);
    endtask

    // ------------------------------------------------------------------
    // m_ side

    initial begin
        wait (aresetn === 1'b1);
        forever begin
            if (stall_sink) begin
                // long hold so the pipe fills and s_ready drops
                m_ready <= 1'b0;
                repeat (SINK_STALL) @(posedge aclk);
                stall_sink = 1'b0;
            end else if ($urandom_range(0, 99) < idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    initial begin
        #500_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i % 100 == 0)
                idle_pct = 25 * $urandom_range(0, 2);
            if (i >= QUIET_FROM)
                idle_pct = 0;
            if (i == 300 || i == 900)
                stall_sink = 1'b1;
            send_beat(random_beat(pick_opcode()));
            maybe_pause_sender();
        end
        s_valid <= 1'b0;

        for (int n = 0; n < 10000 && sb.expected_q.size() != 0; n++)
            @(posedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        repeat (10) @(posedge aclk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ x86_64_near_branch_resolver.f @@
+incdir+hdl
hdl/nbr_pkg.sv
hdl/nbr_exec.sv
hdl/x86_64_near_branch_resolver.sv
tb/x86_64_near_branch_resolver_test.sv
